### sv/sbl_pkg.sv
// ----------------------------------------------------------------------------
// sbl_pkg
// Shared constants, register map, sequencer states and lane control bundle
// for the stack blur line pass.
// ----------------------------------------------------------------------------
package sbl_pkg;

  // Default largest radius the window store is sized for
  localparam int MAX_RADIUS_DEF = 32;

  // Field widths
  localparam int CHAN_W   = 8;
  localparam int LANES    = 4;
  localparam int PIX_W    = CHAN_W * LANES;
  localparam int RADIUS_W = 6;
  localparam int MULT_W   = 16;
  localparam int SHIFT_W  = 5;
  localparam int SEEN_W   = 7;
  localparam int CNT_W    = 7;   // tap counter, up to twice the radius
  localparam int WGT_W    = 7;   // tap weight, up to radius plus one
  localparam int ACC_W    = 20;  // weighted channel sum
  localparam int PROD_W   = ACC_W + MULT_W;

  localparam logic [SEEN_W-1:0] SEEN_MAX = {SEEN_W{1'b1}};

  // APB register map
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;
  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_MULT   = 2'd1;
  localparam logic [1:0] REG_SHIFT  = 2'd2;

  localparam logic [RADIUS_W-1:0] RADIUS_RST = 6'd2;
  localparam logic [MULT_W-1:0]   MULT_RST   = 16'd1;
  localparam logic [SHIFT_W-1:0]  SHIFT_RST  = 5'd0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_ACC,
    ST_SCALE,
    ST_LOAD
  } sbl_state_e;

  typedef struct packed {
    logic              acc_en;
    logic              acc_first;
    logic [WGT_W-1:0]  wgt;
    logic              scale_en;
  } sbl_lane_ctrl_t;

endpackage

### sv/stack_blur_line_pass.sv
// ----------------------------------------------------------------------------
// stack_blur_line_pass
// Per output: 2R+1 window reads (R = line radius), final sum, multiply, beat load.
// Input: a pixel that yields no output is taken while idle; one that yields
//   output stalls the input until its beats are loaded, and the line's last
//   pixel releases min(n,R)+1 beats, n being the pixels before it.
// Reset: control, config, sums and output valid clear at once; the window
//   store, working registers and beat are not; the store needs no clearing pass.
// ----------------------------------------------------------------------------
//
// One-dimensional stack blur over a line of RGBA8 pixels. Each accepted pixel
// is written into a circular window of 2*MAX_RADIUS+1 slots. When an output
// is due, the sequencer walks the 2R+1 taps of the triangle kernel, clamping
// taps at both line edges, and four channel lanes accumulate byte*weight in
// parallel. The merge stage packs the four scaled bytes into one beat.
//
// The window store's single read port sets the pace: one tap per cycle.
module stack_blur_line_pass #(
  parameter int MAX_RADIUS = sbl_pkg::MAX_RADIUS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // pixel in
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [sbl_pkg::CHAN_W-1:0]       red_in_i,
  input  logic [sbl_pkg::CHAN_W-1:0]       green_in_i,
  input  logic [sbl_pkg::CHAN_W-1:0]       blue_in_i,
  input  logic [sbl_pkg::CHAN_W-1:0]       alpha_in_i,
  input  logic                             line_end_in_i,
  // blurred pixel out
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [sbl_pkg::CHAN_W-1:0]       red_out_o,
  output logic [sbl_pkg::CHAN_W-1:0]       green_out_o,
  output logic [sbl_pkg::CHAN_W-1:0]       blue_out_o,
  output logic [sbl_pkg::CHAN_W-1:0]       alpha_out_o,
  output logic                             line_end_out_o,
  // configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [sbl_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [sbl_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [sbl_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready
);

  localparam int DEPTH = 2 * MAX_RADIUS + 1;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int TS_W  = sbl_pkg::CNT_W + 2;   // signed-safe tap distance

  localparam logic [IDX_W-1:0]             LAST_SLOT  = IDX_W'(DEPTH - 1);
  localparam logic [sbl_pkg::RADIUS_W-1:0] RADIUS_CAP = sbl_pkg::RADIUS_W'(MAX_RADIUS);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [sbl_pkg::RADIUS_W-1:0] cfg_radius_q;
  logic [sbl_pkg::MULT_W-1:0]   cfg_mult_q;
  logic [sbl_pkg::SHIFT_W-1:0]  cfg_shift_q;
  logic [1:0]                   reg_idx;
  logic                         cfg_wr;

  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_radius_q <= sbl_pkg::RADIUS_RST;
      cfg_mult_q   <= sbl_pkg::MULT_RST;
      cfg_shift_q  <= sbl_pkg::SHIFT_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        sbl_pkg::REG_RADIUS: cfg_radius_q <= pwdata[sbl_pkg::RADIUS_W-1:0];
        sbl_pkg::REG_MULT:   cfg_mult_q   <= pwdata[sbl_pkg::MULT_W-1:0];
        sbl_pkg::REG_SHIFT:  cfg_shift_q  <= pwdata[sbl_pkg::SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      sbl_pkg::REG_RADIUS: prdata = sbl_pkg::APB_DATA_W'(cfg_radius_q);
      sbl_pkg::REG_MULT:   prdata = sbl_pkg::APB_DATA_W'(cfg_mult_q);
      sbl_pkg::REG_SHIFT:  prdata = sbl_pkg::APB_DATA_W'(cfg_shift_q);
      default:             prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer state
  // --------------------------------------------------------------------------
  sbl_pkg::sbl_state_e state_q, state_d;

  logic [IDX_W-1:0]             wptr_q;       // next slot to write
  logic [sbl_pkg::SEEN_W-1:0]   seen_q;       // pixels of this line so far
  logic [sbl_pkg::RADIUS_W-1:0] line_r_q;     // radius latched at line start
  logic [IDX_W-1:0]             slot_q;       // slot of the newest pixel
  logic [sbl_pkg::SEEN_W-1:0]   n_q;          // index of the newest pixel
  logic                         last_q;       // item closes the line
  logic [sbl_pkg::RADIUS_W-1:0] d_q;          // output distance behind newest
  logic [sbl_pkg::CNT_W-1:0]    j_q;          // tap counter, 0 .. 2R
  logic                         tap_vld_q;
  logic                         tap_first_q;
  logic [sbl_pkg::WGT_W-1:0]    wgt_q;

  logic                         in_acc;
  logic [sbl_pkg::RADIUS_W-1:0] r_cap;
  logic [sbl_pkg::RADIUS_W-1:0] r_eff;
  logic [sbl_pkg::RADIUS_W-1:0] d_first;
  logic                         emits;
  logic [sbl_pkg::CNT_W-1:0]    r2;
  logic                         issue;
  logic                         load;
  logic                         scale_en;
  logic                         out_free;
  logic                         more;
  logic [TS_W-1:0]              tap_dist;
  logic [sbl_pkg::CNT_W-1:0]    back;
  logic [sbl_pkg::WGT_W-1:0]    wgt_d;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign r_cap   = (cfg_radius_q > RADIUS_CAP) ? RADIUS_CAP : cfg_radius_q;
  // latch the radius at the first pixel of a line
  assign r_eff   = (seen_q == '0) ? r_cap : line_r_q;
  assign emits   = line_end_in_i || (seen_q >= sbl_pkg::SEEN_W'(r_eff));
  // a closing pixel flushes from min(n,R) down to zero
  assign d_first = (line_end_in_i && (seen_q < sbl_pkg::SEEN_W'(r_eff))) ?
                   seen_q[sbl_pkg::RADIUS_W-1:0] : r_eff;
  assign r2      = {line_r_q, 1'b0};
  assign more    = last_q && (d_q != '0);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sbl_pkg::ST_IDLE: begin
        if (in_acc && emits) begin
          state_d = sbl_pkg::ST_SWEEP;
        end
      end
      sbl_pkg::ST_SWEEP: begin
        if (j_q == r2) begin
          state_d = sbl_pkg::ST_ACC;
        end
      end
      sbl_pkg::ST_ACC:   state_d = sbl_pkg::ST_SCALE;
      sbl_pkg::ST_SCALE: state_d = sbl_pkg::ST_LOAD;
      sbl_pkg::ST_LOAD: begin
        if (out_free) begin
          state_d = more ? sbl_pkg::ST_SWEEP : sbl_pkg::ST_IDLE;
        end
      end
      default: state_d = sbl_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall_o = 1'b1;
    issue      = 1'b0;
    scale_en   = 1'b0;
    load       = 1'b0;
    case (state_q)
      sbl_pkg::ST_IDLE:  in_stall_o = 1'b0;
      sbl_pkg::ST_SWEEP: issue      = 1'b1;
      sbl_pkg::ST_ACC:   ;
      sbl_pkg::ST_SCALE: scale_en   = 1'b1;
      sbl_pkg::ST_LOAD:  load       = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sbl_pkg::ST_IDLE;
      wptr_q      <= '0;
      seen_q      <= '0;
      line_r_q    <= sbl_pkg::RADIUS_RST;
      tap_vld_q   <= 1'b0;
      tap_first_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tap_vld_q   <= issue;
      tap_first_q <= issue && (j_q == '0);
      if (in_acc) begin
        line_r_q <= r_eff;
        wptr_q   <= (wptr_q == LAST_SLOT) ? '0 : wptr_q + 1'b1;
        if (line_end_in_i) begin
          seen_q <= '0;
        end else if (seen_q != sbl_pkg::SEEN_MAX) begin
          seen_q <= seen_q + 1'b1;
        end
      end
    end
  end

  // per-item working registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      slot_q <= wptr_q;
      n_q    <= seen_q;
      last_q <= line_end_in_i;
      d_q    <= d_first;
      j_q    <= '0;
    end else if (issue) begin
      j_q <= j_q + 1'b1;
    end else if (load && more) begin
      d_q <= d_q - 1'b1;
      j_q <= '0;
    end
    wgt_q <= wgt_d;
  end

  // --------------------------------------------------------------------------
  // Tap address and weight
  // --------------------------------------------------------------------------
  // tap j sits d + R - j pixels behind the newest, clamped to the line
  always_comb begin
    tap_dist = TS_W'(d_q) + TS_W'(line_r_q);
    if (tap_dist < TS_W'(j_q)) begin
      back = '0;
    end else begin
      tap_dist = tap_dist - TS_W'(j_q);
      if (tap_dist > TS_W'(n_q)) begin
        back = n_q;
      end else begin
        back = tap_dist[sbl_pkg::CNT_W-1:0];
      end
    end
    // triangle weight: rises to R+1 at the centre tap, then falls
    if (j_q < sbl_pkg::CNT_W'(line_r_q)) begin
      wgt_d = sbl_pkg::WGT_W'(j_q + 1'b1);
    end else begin
      wgt_d = sbl_pkg::WGT_W'(r2 + 1'b1 - j_q);
    end
  end

  // --------------------------------------------------------------------------
  // Window store
  // --------------------------------------------------------------------------
  logic [sbl_pkg::PIX_W-1:0] tap_pix;

  sbl_window #(
    .MAX_RADIUS(MAX_RADIUS)
  ) u_window (
    .clk_i     (clk_i),
    .wr_en_i   (in_acc),
    .wr_addr_i (wptr_q),
    .wr_data_i ({alpha_in_i, blue_in_i, green_in_i, red_in_i}),
    .slot_i    (slot_q),
    .back_i    (back),
    .rd_data_o (tap_pix)
  );

  // --------------------------------------------------------------------------
  // Channel lanes
  // --------------------------------------------------------------------------
  sbl_pkg::sbl_lane_ctrl_t lane_ctrl;
  logic [sbl_pkg::LANES-1:0][sbl_pkg::CHAN_W-1:0] lane_chan;
  logic [sbl_pkg::LANES-1:0][sbl_pkg::CHAN_W-1:0] out_chan;

  always_comb begin
    lane_ctrl.acc_en    = tap_vld_q;
    lane_ctrl.acc_first = tap_first_q;
    lane_ctrl.wgt       = wgt_q;
    lane_ctrl.scale_en  = scale_en;
  end

  for (genvar l = 0; l < sbl_pkg::LANES; l++) begin : g_lane
    sbl_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (lane_ctrl),
      .tap_i   (tap_pix[sbl_pkg::CHAN_W*l +: sbl_pkg::CHAN_W]),
      .mult_i  (cfg_mult_q),
      .shift_i (cfg_shift_q),
      .chan_o  (lane_chan[l])
    );
  end

  // --------------------------------------------------------------------------
  // Merge into the output beat
  // --------------------------------------------------------------------------
  sbl_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .chan_i      (lane_chan),
    .line_end_i  (last_q && (d_q == '0)),
    .out_stall_i (out_stall_i),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .chan_o      (out_chan),
    .line_end_o  (line_end_out_o)
  );

  assign red_out_o   = out_chan[0];
  assign green_out_o = out_chan[1];
  assign blue_out_o  = out_chan[2];
  assign alpha_out_o = out_chan[3];

endmodule

### sv/sbl_window.sv
// ----------------------------------------------------------------------------
// sbl_window
// Circular pixel window: one write port, one registered read port addressed
// by the newest slot and a distance back from it.
// ----------------------------------------------------------------------------
module sbl_window #(
  parameter int MAX_RADIUS = sbl_pkg::MAX_RADIUS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  wr_en_i,
  input  logic [$clog2(2*MAX_RADIUS+1)-1:0]     wr_addr_i,
  input  logic [sbl_pkg::PIX_W-1:0]             wr_data_i,
  input  logic [$clog2(2*MAX_RADIUS+1)-1:0]     slot_i,
  input  logic [sbl_pkg::CNT_W-1:0]             back_i,
  output logic [sbl_pkg::PIX_W-1:0]             rd_data_o
);

  localparam int DEPTH = 2 * MAX_RADIUS + 1;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int SUM_W = sbl_pkg::CNT_W + 1;

  logic [sbl_pkg::PIX_W-1:0] mem [DEPTH];
  logic [SUM_W-1:0]          raw;
  logic [SUM_W-1:0]          wrapped;
  logic [IDX_W-1:0]          rd_addr;

  // slot - back modulo DEPTH; back never exceeds DEPTH - 1
  always_comb begin
    raw = SUM_W'(slot_i) + SUM_W'(DEPTH) - SUM_W'(back_i);
    if (raw >= SUM_W'(DEPTH)) begin
      wrapped = raw - SUM_W'(DEPTH);
    end else begin
      wrapped = raw;
    end
    rd_addr = wrapped[IDX_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_o <= mem[rd_addr];
  end

endmodule

### sv/sbl_lane.sv
// ----------------------------------------------------------------------------
// sbl_lane
// One channel lane: weighted tap accumulation, then normalising multiply.
// ----------------------------------------------------------------------------
module sbl_lane (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  sbl_pkg::sbl_lane_ctrl_t        ctrl_i,
  input  logic [sbl_pkg::CHAN_W-1:0]     tap_i,
  input  logic [sbl_pkg::MULT_W-1:0]     mult_i,
  input  logic [sbl_pkg::SHIFT_W-1:0]    shift_i,
  output logic [sbl_pkg::CHAN_W-1:0]     chan_o
);

  localparam int TERM_W = sbl_pkg::CHAN_W + sbl_pkg::WGT_W;

  logic [sbl_pkg::ACC_W-1:0]  acc_q, acc_d;
  logic [sbl_pkg::PROD_W-1:0] prod_q, prod_d;
  logic [TERM_W-1:0]          term;
  logic [sbl_pkg::PROD_W-1:0] shifted;

  always_comb begin
    term = TERM_W'(tap_i) * TERM_W'(ctrl_i.wgt);
    acc_d = acc_q;
    if (ctrl_i.acc_en) begin
      acc_d = (ctrl_i.acc_first ? '0 : acc_q) + sbl_pkg::ACC_W'(term);
    end
    prod_d = sbl_pkg::PROD_W'(acc_q) * sbl_pkg::PROD_W'(mult_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.scale_en) begin
      prod_q <= prod_d;
    end
  end

  assign shifted = prod_q >> shift_i;
  assign chan_o  = shifted[sbl_pkg::CHAN_W-1:0];

endmodule

### sv/sbl_merge.sv
// ----------------------------------------------------------------------------
// sbl_merge
// Gather the four lane results into one output beat and hold it until taken.
// ----------------------------------------------------------------------------
module sbl_merge (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          load_i,
  input  logic [sbl_pkg::LANES-1:0][sbl_pkg::CHAN_W-1:0] chan_i,
  input  logic                                          line_end_i,
  input  logic                                          out_stall_i,
  output logic                                          free_o,
  output logic                                          out_valid_o,
  output logic [sbl_pkg::LANES-1:0][sbl_pkg::CHAN_W-1:0] chan_o,
  output logic                                          line_end_o
);

  logic vld_q, vld_d;

  assign free_o = !vld_q || !out_stall_i;

  always_comb begin
    vld_d = vld_q && out_stall_i;
    if (load_i) begin
      vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      chan_o     <= chan_i;
      line_end_o <= line_end_i;
    end
  end

  assign out_valid_o = vld_q;

endmodule

### tb/sbl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbl_checker
// Watches the pixel, blurred-pixel and register channels of the stack blur
// line pass. Keeps its own copy of the line window and register values,
// works out every blurred beat that an accepted pixel releases and compares
// each returned beat with the oldest one still owed.
// ----------------------------------------------------------------------------
module sbl_checker
  import sbl_pkg::*;
#(
  parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic [CHAN_W-1:0]     red_in_i,
  input  logic [CHAN_W-1:0]     green_in_i,
  input  logic [CHAN_W-1:0]     blue_in_i,
  input  logic [CHAN_W-1:0]     alpha_in_i,
  input  logic                  line_end_in_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic [CHAN_W-1:0]     red_out_i,
  input  logic [CHAN_W-1:0]     green_out_i,
  input  logic [CHAN_W-1:0]     blue_out_i,
  input  logic [CHAN_W-1:0]     alpha_out_i,
  input  logic                  line_end_out_i,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output int unsigned           pending_o,
  output int unsigned           errors_o
);

  localparam int WIN = 2 * MAX_RADIUS + 1;

  // lane 0 red, lane 3 alpha
  typedef struct packed {
    logic                         line_end;
    logic [LANES-1:0][CHAN_W-1:0] chan;
  } blur_beat_t;

  string lane_name [LANES] = '{"red", "green", "blue", "alpha"};

  logic [PIX_W-1:0]    window_q [WIN];
  logic [RADIUS_W-1:0] radius_reg;
  logic [MULT_W-1:0]   gain_reg;
  logic [SHIFT_W-1:0]  shift_reg;
  int unsigned         wr_slot;
  int unsigned         line_pos;
  int unsigned         line_radius;
  int unsigned         fail_count;
  blur_beat_t          blurred_q [$];

  // Triangle-weighted sum around the pixel 'offs' places behind the newest,
  // taps clamped to the first and last pixel seen on this line.
  function automatic blur_beat_t blur_at(int unsigned newest, int unsigned seen,
                                         int unsigned offs, int unsigned r,
                                         logic is_last);
    blur_beat_t        beat;
    logic [ACC_W-1:0]  acc [LANES];
    logic [PROD_W-1:0] prod;
    int                back;
    int                slot;
    int                wgt;
    for (int c = 0; c < LANES; c++) acc[c] = '0;
    for (int k = -int'(r); k <= int'(r); k++) begin
      back = int'(offs) - k;
      if (back < 0) back = 0;
      if (back > int'(seen)) back = int'(seen);
      slot = (int'(newest) + WIN - back) % WIN;
      wgt  = int'(r) + 1 - ((k < 0) ? -k : k);
      for (int c = 0; c < LANES; c++)
        acc[c] += window_q[slot][c*CHAN_W +: CHAN_W] * wgt;
    end
    for (int c = 0; c < LANES; c++) begin
      prod = acc[c] * gain_reg;
      prod = prod >> shift_reg;
      beat.chan[c] = prod[CHAN_W-1:0];
    end
    beat.line_end = is_last;
    return beat;
  endfunction

  task automatic absorb_pixel(input logic [PIX_W-1:0] px, input logic is_last);
    int unsigned slot;
    int unsigned seen;
    int unsigned reach;
    slot = wr_slot;
    seen = line_pos;
    // radius is latched on the first pixel of each line
    if (seen == 0) line_radius = (radius_reg > MAX_RADIUS) ? MAX_RADIUS : radius_reg;
    window_q[slot] = px;
    wr_slot = (slot + 1) % WIN;
    if (is_last) begin
      reach = (seen < line_radius) ? seen : line_radius;
      for (int d = int'(reach); d >= 0; d--)
        blurred_q.push_back(blur_at(slot, seen, d, line_radius, d == 0));
      line_pos = 0;
    end else begin
      if (seen >= line_radius)
        blurred_q.push_back(blur_at(slot, seen, line_radius, line_radius, 1'b0));
      if (line_pos < SEEN_MAX) line_pos++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    blur_beat_t got;
    blur_beat_t want;
    if (!rst_ni) begin
      radius_reg  = RADIUS_RST;
      gain_reg    = MULT_RST;
      shift_reg   = SHIFT_RST;
      wr_slot     = 0;
      line_pos    = 0;
      line_radius = RADIUS_RST;
      fail_count  = 0;
      for (int i = 0; i < WIN; i++) window_q[i] = '0;
      blurred_q.delete();
      pending_o <= 0;
      errors_o  <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[APB_ADDR_W-1:2])
          REG_RADIUS: radius_reg = pwdata[RADIUS_W-1:0];
          REG_MULT:   gain_reg   = pwdata[MULT_W-1:0];
          REG_SHIFT:  shift_reg  = pwdata[SHIFT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i)
        absorb_pixel({alpha_in_i, blue_in_i, green_in_i, red_in_i}, line_end_in_i);
      if (out_valid_i && !out_stall_i) begin
        got.chan     = {alpha_out_i, blue_out_i, green_out_i, red_out_i};
        got.line_end = line_end_out_i;
        if (blurred_q.size() == 0) begin
          $display("%0t: unexpected blurred beat, expected none, got %h", $time, got);
          fail_count++;
        end else begin
          want = blurred_q.pop_front();
          for (int c = 0; c < LANES; c++) begin
            if (got.chan[c] !== want.chan[c]) begin
              $display("%0t: %s mismatch, expected %02h, got %02h", $time,
                       lane_name[c], want.chan[c], got.chan[c]);
              fail_count++;
            end
          end
          if (got.line_end !== want.line_end) begin
            $display("%0t: line_end mismatch, expected %0b, got %0b", $time,
                     want.line_end, got.line_end);
            fail_count++;
          end
        end
      end
      pending_o <= blurred_q.size();
      errors_o  <= fail_count;
    end
  end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the stack blur line pass: a short directed run
// over edge cases, then random lines under varying register settings and
// flow-control pressure, with all checking done by sbl_checker.
// ----------------------------------------------------------------------------
module tb;
  import sbl_pkg::*;

  // Quiet time after the last owed beat: one full output at the largest
  // radius plus some margin, so no pixel is still in flight.
  localparam int SETTLE      = 2 * MAX_RADIUS_DEF + 8;
  localparam int CYCLE_LIMIT = 2000000;

  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  in_valid_i     = 1'b0;
  logic                  in_stall_o;
  logic [CHAN_W-1:0]     red_in_i       = '0;
  logic [CHAN_W-1:0]     green_in_i     = '0;
  logic [CHAN_W-1:0]     blue_in_i      = '0;
  logic [CHAN_W-1:0]     alpha_in_i     = '0;
  logic                  line_end_in_i  = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i    = 1'b0;
  logic [CHAN_W-1:0]     red_out_o;
  logic [CHAN_W-1:0]     green_out_o;
  logic [CHAN_W-1:0]     blue_out_o;
  logic [CHAN_W-1:0]     alpha_out_o;
  logic                  line_end_out_o;
  logic                  psel           = 1'b0;
  logic                  penable        = 1'b0;
  logic                  pwrite         = 1'b0;
  logic [APB_ADDR_W-1:0] paddr          = '0;
  logic [APB_DATA_W-1:0] pwdata         = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int unsigned pending;
  int unsigned errors;

  // Flow-control knobs, in percent of cycles
  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;

  int unsigned pixels_sent   = 0;
  int unsigned lines_sent    = 0;
  int unsigned settings_used = 0;
  int unsigned line_left     = 0;

  always #5 clk_i = ~clk_i;

  stack_blur_line_pass dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .red_in_i       (red_in_i),
    .green_in_i     (green_in_i),
    .blue_in_i      (blue_in_i),
    .alpha_in_i     (alpha_in_i),
    .line_end_in_i  (line_end_in_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .red_out_o      (red_out_o),
    .green_out_o    (green_out_o),
    .blue_out_o     (blue_out_o),
    .alpha_out_o    (alpha_out_o),
    .line_end_out_o (line_end_out_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  sbl_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .red_in_i       (red_in_i),
    .green_in_i     (green_in_i),
    .blue_in_i      (blue_in_i),
    .alpha_in_i     (alpha_in_i),
    .line_end_in_i  (line_end_in_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .red_out_i      (red_out_o),
    .green_out_i    (green_out_o),
    .blue_out_i     (blue_out_o),
    .alpha_out_i    (alpha_out_o),
    .line_end_out_i (line_end_out_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pending_o      (pending),
    .errors_o       (errors)
  );

  // Receiver: stall on a random share of cycles, chosen afresh every edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < sink_stall_pct);
    end
  end

  // Watchdog: a correct run ends long before this.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("stack_blur_line_pass verification failed");
    $finish;
  end

  // Offer one pixel beat and hold it until the block takes it. Idle cycles
  // go in front of the beat; valid is only dropped inside that gap, so a
  // back-to-back beat never sees valid lowered and raised in one step.
  task automatic send_pixel(input logic [PIX_W-1:0] px, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    red_in_i      <= px[0*CHAN_W +: CHAN_W];
    green_in_i    <= px[1*CHAN_W +: CHAN_W];
    blue_in_i     <= px[2*CHAN_W +: CHAN_W];
    alpha_in_i    <= px[3*CHAN_W +: CHAN_W];
    line_end_in_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pixels_sent++;
    if (last) lines_sent++;
  endtask

  // Setup cycle, access cycle, then back to idle with psel low, so that
  // back-to-back writes never touch psel twice in one step.
  task automatic program_reg(input logic [1:0] idx, input logic [APB_DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Hold the sender off until every owed beat has come back, then let the
  // block run dry. The pending count seen here is registered in the checker,
  // hence the first step.
  task automatic drain_and_settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic quiesce_and_program(input int unsigned radius, input int unsigned gain,
                                     input int unsigned shift);
    drain_and_settle();
    program_reg(REG_RADIUS, radius);
    program_reg(REG_MULT, gain);
    program_reg(REG_SHIFT, shift);
    settings_used++;
  endtask

  // One register setting and one flow-control mix; lines of random length
  // and content. A line may run over the end of a phase, so the next
  // setting lands mid-line.
  task automatic run_phase(input int unsigned radius, input int unsigned gain,
                           input int unsigned shift, input int unsigned src_pct,
                           input int unsigned sink_pct, input int unsigned items,
                           input int unsigned len_lo, input int unsigned len_hi);
    quiesce_and_program(radius, gain, shift);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    repeat (items) begin
      if (line_left == 0) line_left = $urandom_range(len_hi, len_lo);
      line_left--;
      send_pixel($urandom, line_left == 0);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- Directed part, reset settings first: radius 2, unit gain ---------
    // single-pixel line: both edges clamp onto the same pixel
    send_pixel(32'hFFFF_FFFF, 1'b1);
    // short line, fewer pixels than radius plus one: all flushed at the end
    send_pixel(32'h0000_0000, 1'b0);
    send_pixel(32'hFFFF_FFFF, 1'b1);
    // walking and alternating bit patterns; sums overflow the low byte
    send_pixel(32'h5555_5555, 1'b0);
    send_pixel(32'hAAAA_AAAA, 1'b0);
    send_pixel(32'h0102_0408, 1'b0);
    send_pixel(32'h8040_2010, 1'b0);
    send_pixel(32'hFF00_FF00, 1'b0);
    send_pixel(32'h00FF_00FF, 1'b1);

    // radius zero with the largest gain and shift
    quiesce_and_program(0, 16'hFFFF, 31);
    send_pixel(32'h1234_5678, 1'b0);
    send_pixel(32'h9ABC_DEF0, 1'b0);
    send_pixel(32'hFFFF_FFFF, 1'b1);

    // radius above the maximum: saturates; a four-pixel line is short
    quiesce_and_program(63, 1, 0);
    send_pixel(32'hFEDC_BA98, 1'b0);
    send_pixel(32'h7654_3210, 1'b0);
    send_pixel(32'hC3C3_3C3C, 1'b0);
    send_pixel(32'h0F0F_F0F0, 1'b1);

    // radius rewritten mid-line: this line keeps the saturated radius,
    // the next one takes radius 1
    send_pixel(32'h1111_EEEE, 1'b0);
    send_pixel(32'h2222_DDDD, 1'b0);
    send_pixel(32'h3333_CCCC, 1'b0);
    quiesce_and_program(1, 16'h4000, 16);
    send_pixel(32'h4444_BBBB, 1'b0);
    send_pixel(32'h5555_AAAA, 1'b0);
    send_pixel(32'h6666_9999, 1'b1);
    send_pixel(32'hFFFF_0000, 1'b0);
    send_pixel(32'h0000_FFFF, 1'b0);
    send_pixel(32'h8080_0101, 1'b1);

    // --- Random part --------------------------------------------------------
    // radius 1, gain about a quarter, no idling
    run_phase(1, 16384, 16, 0, 0, 12, 1, 6);
    // radius 3, gain a sixteenth, sender idle most cycles
    run_phase(3, 4096, 16, 57, 0, 12, 2, 10);
    // largest radius, lines long enough for a full 33-beat flush,
    // receiver stalling most cycles
    run_phase(32, 16'hFFFF, 31, 0, 57, 40, 34, 38);
    // random setting, light idling on both sides
    run_phase($urandom_range(31, 4), $urandom_range(65535), $urandom_range(31),
              12, 12, 12, 1, 24);
    // radius zero and zero gain: every channel must come back zero
    run_phase(0, 0, 0, 0, 0, 8, 1, 4);
    // saturating radius, random gain and shift, both sides idling a lot
    run_phase($urandom_range(63, 33), $urandom_range(65535), $urandom_range(31),
              57, 57, 12, 1, 12);

    // close the open line so every pixel has been blurred
    while (line_left != 0) begin
      line_left--;
      send_pixel($urandom, line_left == 0);
    end
    drain_and_settle();

    $display("Run covered %0d pixels in %0d lines over %0d register settings,",
             pixels_sent, lines_sent, settings_used + 1);
    $display("radius 0 to 63, gain and shift at both ends, with idle and stall mixes.");
    if (errors == 0 && pending == 0) begin
      $display("stack_blur_line_pass verification clean");
    end else begin
      $display("stack_blur_line_pass verification failed");
    end
    $finish;
  end

endmodule

### stack_blur_line_pass.f
sv/sbl_pkg.sv
sv/sbl_window.sv
sv/sbl_lane.sv
sv/sbl_merge.sv
sv/stack_blur_line_pass.sv
tb/sbl_checker.sv
tb/tb.sv
